// ===== src/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// btpc_pkg
// shared types and constants of the barometric compensation unit
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam logic [19:0] SKIP_CODE = 20'h80000;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP      = 2'd0;
  localparam logic [1:0] REG_PRESS_LO  = 2'd1;
  localparam logic [1:0] REG_PRESS_HI  = 2'd2;
  localparam logic [1:0] REG_PRESS_P9  = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALU,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture input item
    logic       step;      // run one micro-op
    logic [4:0] op;        // micro-op index
    logic       div_start; // start the divider
    logic       div_step;  // one quotient bit
    logic       finish;    // compose the result item
  } btpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic div_zero;
  } btpc_sts_t;

  localparam int DivBits = 32;

endpackage

// ===== src/btpc_datapath.sv =====
// ----------------------------------------------------------------------------
// btpc_datapath
// registers, one shared 32x32 multiplier and a serial restoring divider
// ----------------------------------------------------------------------------
module btpc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [63:0]         cfg_wdata,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  btpc_pkg::btpc_cmd_t cmd,
  output btpc_pkg::btpc_sts_t sts,
  output logic [31:0]         temp_out,
  output logic                temp_ok,
  output logic [31:0]         press_out,
  output logic                press_ok
);

  logic [47:0] tc_r;
  logic [63:0] pl_r, ph_r;
  logic [15:0] p9_r;
  logic [31:0] fine_r;
  logic [19:0] ut_r, up_r;
  // scratch registers
  logic [31:0] a_r, b_r, d_r, q_r, m_r, p_r, t_r;
  logic [31:0] a_nxt, b_nxt, d_nxt, q_nxt, m_nxt, p_nxt, t_nxt, fine_nxt;
  // divider
  logic [31:0] dq_r, drem_r, ddiv_r;
  logic [5:0]  dcnt_r;
  logic        dbig_r;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] ma, mb, mul;
  logic [63:0] prod;
  logic [32:0] trial;

  function automatic logic [31:0] sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    asr = 32'($signed(x) >>> n);
  endfunction

  assign t1 = {16'd0, tc_r[15:0]};
  assign t2 = sx(tc_r[31:16]);
  assign t3 = sx(tc_r[47:32]);
  assign p1 = {16'd0, pl_r[15:0]};
  assign p2 = sx(pl_r[31:16]);
  assign p3 = sx(pl_r[47:32]);
  assign p4 = sx(pl_r[63:48]);
  assign p5 = sx(ph_r[15:0]);
  assign p6 = sx(ph_r[31:16]);
  assign p7 = sx(ph_r[47:32]);
  assign p8 = sx(ph_r[63:48]);
  assign p9 = sx(p9_r);

  // configuration and fine temperature registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0; pl_r <= '0; ph_r <= '0; p9_r <= '0; fine_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          btpc_pkg::REG_TEMP:     tc_r <= cfg_wdata[47:0];
          btpc_pkg::REG_PRESS_LO: pl_r <= cfg_wdata;
          btpc_pkg::REG_PRESS_HI: ph_r <= cfg_wdata;
          btpc_pkg::REG_PRESS_P9: p9_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      fine_r <= fine_nxt;
    end
  end

  // multiplier operand selection per micro-op
  always_comb begin
    ma = '0; mb = '0;
    case (cmd.op)
      5'd0:  begin ma = {15'd0, ut_r[19:3]} - (t1 << 1); mb = t2; end
      5'd1:  begin ma = d_r; mb = d_r; end
      5'd2:  begin ma = asr(m_r, 12); mb = t3; end
      5'd3:  begin ma = fine_r; mb = 32'd5; end
      5'd4:  begin ma = q_r; mb = q_r; end
      5'd5:  begin ma = asr(m_r, 11); mb = p6; end
      5'd6:  begin ma = a_r; mb = p5; end
      5'd7:  begin ma = p3; mb = asr(t_r, 13); end
      5'd8:  begin ma = p2; mb = a_r; end
      5'd9:  begin ma = 32'd32768 + a_r; mb = p1; end
      5'd10: begin ma = (32'd1048576 - {12'd0, up_r}) - asr(b_r, 12); mb = 32'd3125; end
      5'd11: begin ma = q_r; mb = q_r; end
      5'd12: begin ma = p9; mb = m_r >> 13; end
      5'd13: begin ma = p_r >> 2; mb = p8; end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign mul  = prod[31:0];

  // micro-op sequence
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; d_nxt = d_r; q_nxt = q_r; m_nxt = m_r;
    p_nxt = p_r; t_nxt = t_r; fine_nxt = fine_r;
    if (cmd.step) begin
      case (cmd.op)
        5'd0:  begin a_nxt = asr(mul, 11); d_nxt = {16'd0, ut_r[19:4]} - t1; end
        5'd1:  m_nxt = mul;
        5'd2:  fine_nxt = a_r + asr(mul, 14);
        5'd3:  begin
          t_nxt = asr(mul + 32'd128, 8);
          a_nxt = asr(fine_r, 1) - 32'd64000;
          q_nxt = asr(asr(fine_r, 1) - 32'd64000, 2);
        end
        5'd4:  begin m_nxt = mul; t_nxt = mul; end
        5'd5:  b_nxt = mul;
        5'd6:  b_nxt = asr(b_r + (mul << 1), 2) + (p4 << 16);
        5'd7:  m_nxt = asr(mul, 3);
        5'd8:  a_nxt = asr(m_r + asr(mul, 1), 18);
        5'd9:  a_nxt = asr(mul, 15);
        5'd10: p_nxt = mul;
        5'd11: m_nxt = mul;
        5'd12: a_nxt = asr(mul, 12);
        5'd13: b_nxt = asr(mul, 13);
        5'd14: p_nxt = p_r + asr(a_r + b_r + p7, 4);
        default: ;
      endcase
    end
    if (cmd.load) begin
      t_nxt = '0;
    end
    // temperature result must survive op 4
    if (cmd.step && cmd.op == 5'd3) d_nxt = asr(mul + 32'd128, 8);
    // quotient drop-in
    if (dcnt_r == 6'd1 && cmd.div_step) begin
      p_nxt = dbig_r ? {trial[32] ? dq_r[30:0] : dq_r[30:0], ~trial[32]} << 1
                     : {dq_r[30:0], ~trial[32]};
      q_nxt = (dbig_r ? ({dq_r[30:0], ~trial[32]} << 1) :
               {dq_r[30:0], ~trial[32]}) >> 3;
    end
  end

  // input capture and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ut_r <= raw_t;
      up_r <= raw_p;
    end
    a_r <= a_nxt; b_r <= b_nxt; d_r <= d_nxt; q_r <= q_nxt;
    m_r <= m_nxt; p_r <= p_nxt; t_r <= t_nxt;
  end

  // serial restoring divider, one quotient bit a cycle
  assign trial = {drem_r, dq_r[31]} - {1'b0, ddiv_r};

  // the dividend is the scaled pressure formed in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dbig_r <= p_nxt[31];
      dq_r   <= p_nxt[31] ? p_nxt : (p_nxt << 1);
      drem_r <= '0;
      ddiv_r <= a_r;
      dcnt_r <= 6'(btpc_pkg::DivBits);
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      if (!trial[32]) drem_r <= trial[31:0];
      else            drem_r <= {drem_r[30:0], dq_r[31]};
      dq_r   <= {dq_r[30:0], ~trial[32]};
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  assign sts.div_done = (dcnt_r == 6'd1);
  assign sts.div_zero = (a_r == 32'd0);

  // result composition, zero divisor is masked at the top level
  always_comb begin
    temp_ok   = (ut_r != btpc_pkg::SKIP_CODE);
    temp_out  = temp_ok ? d_r : 32'd0;
    press_ok  = (up_r != btpc_pkg::SKIP_CODE) && cmd.finish;
    press_out = press_ok ? p_r : 32'd0;
  end

endmodule

// ===== src/btpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// btpc_ctrl
// sequencer that walks the micro-ops and the divider
// ----------------------------------------------------------------------------
module btpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_fire,
  input  logic                skip_t,
  input  logic                skip_p,
  input  btpc_pkg::btpc_sts_t sts,
  output btpc_pkg::btpc_cmd_t cmd,
  output logic                busy,
  output logic                res_valid,
  output logic                zero_div
);

  btpc_pkg::state_t state_r, state_nxt;
  logic [4:0] op_r, op_nxt;
  logic       zd_r, zd_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    zd_nxt    = zd_r;
    case (state_r)
      btpc_pkg::ST_IDLE: if (in_fire) begin
        state_nxt = btpc_pkg::ST_ALU;
        op_nxt    = skip_t ? 5'd3 : 5'd0;
        zd_nxt    = 1'b0;
      end
      btpc_pkg::ST_ALU: begin
        if (op_r == 5'd3 && skip_p) state_nxt = btpc_pkg::ST_OUT;
        else if (op_r == 5'd10) begin
          state_nxt = btpc_pkg::ST_DIV;
          zd_nxt    = sts.div_zero;
          if (sts.div_zero) state_nxt = btpc_pkg::ST_OUT;
        end else op_nxt = op_r + 5'd1;
      end
      btpc_pkg::ST_DIV: if (sts.div_done) begin
        state_nxt = btpc_pkg::ST_POST;
        op_nxt    = 5'd11;
      end
      btpc_pkg::ST_POST: begin
        if (op_r == 5'd14) state_nxt = btpc_pkg::ST_OUT;
        else op_nxt = op_r + 5'd1;
      end
      btpc_pkg::ST_OUT: if (out_fire) state_nxt = btpc_pkg::ST_IDLE;
      default: state_nxt = btpc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.op   = op_r;
    cmd.load = in_fire;
    case (state_r)
      btpc_pkg::ST_ALU: begin
        // skipped temperature leaves op 2 (fine update) out; op 3 still runs
        cmd.step      = 1'b1;
        cmd.div_start = (op_r == 5'd10) && !sts.div_zero;
      end
      btpc_pkg::ST_DIV:  cmd.div_step = 1'b1;
      btpc_pkg::ST_POST: cmd.step = 1'b1;
      btpc_pkg::ST_OUT:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

  assign busy      = (state_r != btpc_pkg::ST_IDLE);
  assign res_valid = (state_r == btpc_pkg::ST_OUT);
  assign zero_div  = zd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btpc_pkg::ST_IDLE;
      op_r    <= '0;
      zd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      zd_r    <= zd_nxt;
    end
  end

endmodule

// ===== src/baro_temp_press_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_unit
// 32-bit integer temperature and pressure compensation for a barometer
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one item: a raw temperature and a raw pressure sample.
//   out_* returns one item per input: compensated temperature in 0.01 degree
//   with its valid flag, pressure in pascal with its valid flag.
//   cfg_* writes the four calibration registers; write them only while the unit is idle, the unit does not enforce it.
// sequencing:
//   one item at a time; after the accepting edge the unit runs the micro-ops,
//   the bit-serial divider and the post micro-ops, then raises out_tvalid.
//   in_tready returns the cycle after the result is taken, so a new item is
//   taken only after the last result has gone. A skipped temperature starts
//   at op 3, a skipped pressure ends after op 3 and a zero divisor ends after
//   op 10 without the divider. in_tready is high only while idle.
// reset:
//   rst_n clears the coefficients and the fine temperature to zero.
// stall:
//   the result is held in out_tdata with out_tvalid high until out_tready.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // temperature_centi[31:0], temperature_valid[32],
                                  // pressure_pa[64:33], pressure_valid[65], zero fill
);

  btpc_pkg::btpc_cmd_t cmd;
  btpc_pkg::btpc_sts_t sts;
  logic        busy, zero_div, in_fire, out_fire;
  logic [31:0] t_out, p_out;
  logic        t_ok, p_ok;
  logic        u_dp_skip_p;
  logic [19:0] up_hold_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  btpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .skip_t(in_tdata[19:0] == btpc_pkg::SKIP_CODE),
    .skip_p(u_dp_skip_p), .sts(sts), .cmd(cmd), .busy(busy),
    .res_valid(out_tvalid), .zero_div(zero_div)
  );

  always_ff @(posedge clk) begin
    if (in_fire) up_hold_r <= in_tdata[39:20];
  end
  assign u_dp_skip_p = (up_hold_r == btpc_pkg::SKIP_CODE);

  btpc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .raw_t(in_tdata[19:0]), .raw_p(in_tdata[39:20]),
    .cmd(cmd), .sts(sts), .temp_out(t_out), .temp_ok(t_ok),
    .press_out(p_out), .press_ok(p_ok)
  );

  assign out_tdata = {6'd0, p_ok && !zero_div, (p_ok && !zero_div) ? p_out : 32'd0,
                      t_ok, t_out};

  // result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");
  // no new item accepted while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while result pending");
  // skipped pressure never flagged valid
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && u_dp_skip_p |-> !out_tdata[65])
    else $error("skipped pressure flagged valid");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the barometric compensation unit: calibration sets
// are written while idle, raw sample pairs are streamed in with random gaps
// and back-pressure, and every result item is compared with the local model
// or with a fixed expected item
module tb_top;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;

  // packed from the top bit down, so temp_centi lands in the low bits
  typedef struct packed {
    logic        press_ok;
    logic [31:0] press_pa;
    logic        temp_ok;
    logic [31:0] temp_centi;
  } comp_result_t;

  typedef struct {
    logic [19:0]  raw_t;
    logic [19:0]  raw_p;
    logic         has_gold;
    comp_result_t gold;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  // model copy of calibration and state
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [15:0] cal_p9;
  logic [31:0] model_fine_t;

  comp_result_t pending_results[$];
  int mismatches;
  int results_seen;
  int items_sent;
  int cycles;
  bit stall_enable;

  baro_temp_press_compensation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  // 32-bit wrapping compensation, updates the fine temperature
  function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    comp_result_t r;
    logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, p;
    ut = {12'd0, raw_t};
    up = {12'd0, raw_p};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sext16(cal_temp[31:16]);
    t3 = sext16(cal_temp[47:32]);
    p1 = {16'd0, cal_press_lo[15:0]};
    p2 = sext16(cal_press_lo[31:16]);
    p3 = sext16(cal_press_lo[47:32]);
    p4 = sext16(cal_press_lo[63:48]);
    p5 = sext16(cal_press_hi[15:0]);
    p6 = sext16(cal_press_hi[31:16]);
    p7 = sext16(cal_press_hi[47:32]);
    p8 = sext16(cal_press_hi[63:48]);
    p9 = sext16(cal_p9);
    r = '0;
    if (raw_t != btpc_pkg::SKIP_CODE) begin
      a = sra(((ut >> 3) - (t1 << 1)) * t2, 11);
      d = (ut >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      model_fine_t = a + b;
      r.temp_centi = sra(model_fine_t * 32'd5 + 32'd128, 8);
      r.temp_ok = 1'b1;
    end
    if (raw_p != btpc_pkg::SKIP_CODE) begin
      a = sra(model_fine_t, 1) - 32'd64000;
      q = sra(a, 2);
      b = sra(q * q, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      if (a != 0) begin
        p = ((32'd1048576 - up) - sra(b, 12)) * 32'd3125;
        if (p < 32'h80000000) p = (p << 1) / a;
        else p = (p / a) * 32'd2;
        q = p >> 3;
        a = sra(p9 * ((q * q) >> 13), 12);
        b = sra((p >> 2) * p8, 13);
        p = p + sra(a + b + p7, 4);
        r.press_pa = p;
        r.press_ok = 1'b1;
      end
    end
    return r;
  endfunction

  // one register write, the enable is dropped by the caller
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      btpc_pkg::REG_TEMP:     cal_temp = val[47:0];
      btpc_pkg::REG_PRESS_LO: cal_press_lo = val;
      btpc_pkg::REG_PRESS_HI: cal_press_hi = val;
      btpc_pkg::REG_PRESS_P9: cal_p9 = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                                  logic [15:0] nine);
    write_reg(btpc_pkg::REG_TEMP, {16'd0, tc});
    write_reg(btpc_pkg::REG_PRESS_LO, lo);
    write_reg(btpc_pkg::REG_PRESS_HI, hi);
    write_reg(btpc_pkg::REG_PRESS_P9, {48'd0, nine});
    cfg_we <= 1'b0;
  endtask

  // wait until every expected result is back, then let the unit settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one sample pair and hold it until accepted
  task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p, bit typed,
                             comp_result_t gold);
    comp_result_t predicted;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_p, raw_t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = compensate(raw_t, raw_p);
    pending_results.push_back(typed ? gold : predicted);
    items_sent++;
  endtask

  // realistic calibration around typical factory values, random spread
  task automatic load_typical();
    load_calibration({16'($urandom_range(0, 15) - 8) & 16'hffff ^ 16'hfffe,
                      16'(26000 + $urandom_range(0, 1000)),
                      16'(27000 + $urandom_range(0, 2000))},
                     {16'(2800 + $urandom_range(0, 400)), 16'hd0f5 + 16'($urandom_range(0, 64)),
                      16'hd000 + 16'($urandom_range(0, 2000)),
                      16'(36000 + $urandom_range(0, 2000))},
                     {16'd12 + 16'($urandom_range(0, 5)), 16'hc000 + 16'($urandom_range(0, 2000)),
                      16'hfff9, 16'($urandom_range(0, 800))},
                     16'hbb00 + 16'($urandom_range(0, 400)) ^ 16'h8000);
  endtask

  // result monitor with random back-pressure
  initial begin
    comp_result_t got, want;
    int hold;
    out_tready = 1'b0;
    hold = 0;
    mismatches = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[65:0];
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got.temp_centi !== want.temp_centi || got.temp_ok !== want.temp_ok ||
              got.press_pa !== want.press_pa || got.press_ok !== want.press_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch item %0d: exp t=%0d/%b p=%0d/%b got t=%0d/%b p=%0d/%b",
                       results_seen, $signed(want.temp_centi), want.temp_ok,
                       want.press_pa, want.press_ok, $signed(got.temp_centi),
                       got.temp_ok, got.press_pa, got.press_ok);
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  stim_row_t rows[$];

  initial begin
    comp_result_t g;
    logic [19:0] rt, rp;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    items_sent = 0;
    stall_enable = 1'b1;
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_hi = '0;
    cal_p9 = '0;
    model_fine_t = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset all coefficients are zero: temperature reads zero, divisor is zero
    g = '0; g.temp_ok = 1'b1;
    rows.push_back('{20'h12345, 20'h54321, 1'b1, g});
    g = '0;
    rows.push_back('{btpc_pkg::SKIP_CODE, btpc_pkg::SKIP_CODE, 1'b1, g});
    g = '0; g.temp_ok = 1'b1;
    rows.push_back('{20'hfffff, 20'h00000, 1'b1, g});
    g = '0;
    rows.push_back('{btpc_pkg::SKIP_CODE, 20'hfffff, 1'b1, g});
    foreach (rows[i]) send_sample(rows[i].raw_t, rows[i].raw_p, 1'b1, rows[i].gold);
    wait_drained();

    // typical calibration, field extremes and skip codes, checked by the model
    load_calibration({16'hfc18, 16'd26435, 16'd27504},
                     {16'd2855, 16'hd0d0, 16'hd0ab, 16'd36477},
                     {16'd15500, 16'hc70c, 16'hfff9, 16'd140},
                     16'hbb80 ^ 16'h8000);
    rows.delete();
    g = '0;
    rows.push_back('{20'd519888, 20'd415148, 1'b0, g});
    rows.push_back('{20'h00000, 20'h00000, 1'b0, g});
    rows.push_back('{20'hfffff, 20'hfffff, 1'b0, g});
    rows.push_back('{btpc_pkg::SKIP_CODE, 20'd415148, 1'b0, g});
    rows.push_back('{20'd519888, btpc_pkg::SKIP_CODE, 1'b0, g});
    rows.push_back('{20'h7ffff, 20'h80001, 1'b0, g});
    rows.push_back('{20'h80001, 20'h7ffff, 1'b0, g});
    rows.push_back('{20'haaaaa, 20'h55555, 1'b0, g});
    rows.push_back('{20'h55555, 20'haaaaa, 1'b0, g});
    foreach (rows[i]) send_sample(rows[i].raw_t, rows[i].raw_p, 1'b0, g);
    wait_drained();

    // extreme coefficients: all ones and sign-boundary patterns
    load_calibration('1, '1, '1, 16'hffff);
    send_sample(20'd519888, 20'd415148, 1'b0, g);
    send_sample(20'hfffff, 20'h00000, 1'b0, g);
    wait_drained();
    load_calibration(48'h8000_8000_ffff, 64'h8000_8000_8000_ffff,
                     64'h8000_8000_8000_8000, 16'h8000);
    send_sample(20'h00000, 20'hfffff, 1'b0, g);
    send_sample(20'd300000, 20'd300000, 1'b0, g);
    wait_drained();
    load_calibration(48'h7fff_7fff_0001, 64'h7fff_7fff_7fff_0001,
                     64'h7fff_7fff_7fff_7fff, 16'h7fff);
    send_sample(20'd519888, 20'd415148, 1'b0, g);
    send_sample(btpc_pkg::SKIP_CODE, 20'd1, 1'b0, g);
    wait_drained();

    // random phases: mostly realistic calibration, some fully random
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 3 == 2)
        load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom));
      else
        load_typical();
      if (phase == 7) stall_enable = 1'b0;
      for (int k = 0; k < 48; k++) begin
        case ($urandom_range(0, 9))
          0: begin rt = btpc_pkg::SKIP_CODE; rp = 20'($urandom); end
          1: begin rt = 20'($urandom); rp = btpc_pkg::SKIP_CODE; end
          2: begin rt = 20'($urandom); rp = 20'($urandom); end
          default: begin
            rt = 20'(400000 + $urandom_range(0, 250000));
            rp = 20'(250000 + $urandom_range(0, 250000));
          end
        endcase
        send_sample(rt, rp, 1'b0, g);
      end
      wait_drained();
    end

    $display("covered %0d sample pairs under %0d calibration sets, %0d results checked",
             items_sent, 12, results_seen);
    $display("including skip codes, zero divisors, coefficient extremes and stalls");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("mismatches: %0d, results missing: %0d", mismatches, pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
